### src/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge, reset included
`define AVR_ASSERT(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// switched off while reset is high
`define AVR_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

### src/avr_pkg.sv
package avr_pkg;

   // configuration word and matrix entry formats
   localparam int CFG_WIDTH       = 16;
   localparam int MAT_WIDTH       = 18;
   localparam int MAT_DIM         = 3;
   localparam int MAT_ENTRIES     = MAT_DIM * MAT_DIM;
   localparam int CSR_INDEX_WIDTH = 3;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_X    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_Y    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_Z    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COS_ANGLE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SIN_ANGLE = 3'd4;

   typedef logic signed [CFG_WIDTH-1:0] cfg_word_type;
   typedef logic signed [MAT_WIDTH-1:0] mat_entry_type;
   // row-major, entry 3*row+col
   typedef mat_entry_type [MAT_ENTRIES-1:0] matrix_type;

   // register reset values, unit axis along z and zero angle
   localparam cfg_word_type AXIS_X_RESET    = 16'sd0;
   localparam cfg_word_type AXIS_Y_RESET    = 16'sd0;
   localparam cfg_word_type AXIS_Z_RESET    = 16'sd16384;
   localparam cfg_word_type COS_ANGLE_RESET = 16'sd16384;
   localparam cfg_word_type SIN_ANGLE_RESET = 16'sd0;

endpackage

### src/avr_if.sv
interface avr_req_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_x;
   logic signed [SAMPLE_WIDTH-1:0] sample_y;
   logic signed [SAMPLE_WIDTH-1:0] sample_z;
   logic                           last;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   output last, input ready);
   modport sink (input valid, input sample_x, input sample_y, input sample_z,
                 input last, output ready);
endinterface

interface avr_rsp_if #(parameter int SAMPLE_WIDTH = 16);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] rot_x;
   logic signed [SAMPLE_WIDTH-1:0] rot_y;
   logic signed [SAMPLE_WIDTH-1:0] rot_z;
   logic                           last_out;

   modport source (output valid, output rot_x, output rot_y, output rot_z,
                   output last_out, input ready);
   modport sink (input valid, input rot_x, input rot_y, input rot_z,
                 input last_out, output ready);
endinterface

### src/avr_matrix_builder.sv
module avr_matrix_builder #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [avr_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [avr_pkg::CFG_WIDTH-1:0]        csr_wdata,
   output avr_pkg::matrix_type                  matrix,
   output logic                                 busy
);

   localparam int CW     = avr_pkg::CFG_WIDTH;
   localparam int MW     = avr_pkg::MAT_WIDTH;
   localparam int DIM    = avr_pkg::MAT_DIM;
   localparam int PROD_W = 2 * CW;
   localparam int PS_W   = PROD_W + 1;
   localparam int NN_W   = PS_W - FRAC_BITS;
   localparam int OMC_W  = ((FRAC_BITS > CW) ? FRAC_BITS : CW) + 2;
   localparam int PO_W   = NN_W + OMC_W;
   localparam int ENT_W  = PO_W + 3;

   localparam logic signed [PS_W-1:0]  HALF_P = PS_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [OMC_W-1:0] ONE_Q  = OMC_W'(1) << FRAC_BITS;
   localparam logic signed [ENT_W-1:0] HALF_E = ENT_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ENT_W-1:0] MAT_HI = (ENT_W'(1) << (MW - 1)) - ENT_W'(1);
   localparam logic signed [ENT_W-1:0] MAT_LO = ~MAT_HI;

   avr_pkg::cfg_word_type axis_ff [DIM];
   avr_pkg::cfg_word_type cos_ff;
   avr_pkg::cfg_word_type sin_ff;

   // rebuild tracking, one flag per stage
   logic pend_ff;
   logic sa_vld_ff;
   logic sb_vld_ff;
   logic sc_vld_ff;

   logic signed [PROD_W-1:0] nn_ff  [DIM][DIM];
   logic signed [PROD_W-1:0] sn_ff  [DIM];
   logic signed [OMC_W-1:0]  omc_ff;
   logic signed [NN_W-1:0]   nnr_ff [DIM][DIM];
   logic signed [NN_W-1:0]   snr_ff [DIM];
   logic signed [OMC_W-1:0]  omcb_ff;
   logic signed [PO_W-1:0]   po_ff  [DIM][DIM];
   logic signed [NN_W-1:0]   snc_ff [DIM];

   logic signed [ENT_W-1:0]  cross_e [DIM][DIM];
   logic signed [ENT_W-1:0]  rnd_e   [DIM][DIM];
   logic signed [ENT_W-1:0]  sum_e   [DIM][DIM];
   avr_pkg::mat_entry_type   sat_e   [DIM][DIM];

   avr_pkg::matrix_type      mat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= avr_pkg::AXIS_X_RESET;
         axis_ff[1] <= avr_pkg::AXIS_Y_RESET;
         axis_ff[2] <= avr_pkg::AXIS_Z_RESET;
         cos_ff     <= avr_pkg::COS_ANGLE_RESET;
         sin_ff     <= avr_pkg::SIN_ANGLE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            avr_pkg::REG_AXIS_X:    axis_ff[0] <= $signed(csr_wdata);
            avr_pkg::REG_AXIS_Y:    axis_ff[1] <= $signed(csr_wdata);
            avr_pkg::REG_AXIS_Z:    axis_ff[2] <= $signed(csr_wdata);
            avr_pkg::REG_COS_ANGLE: cos_ff     <= $signed(csr_wdata);
            avr_pkg::REG_SIN_ANGLE: sin_ff     <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // reset starts a build of its own
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= 1'b1;
         sa_vld_ff <= 1'b0;
         sb_vld_ff <= 1'b0;
         sc_vld_ff <= 1'b0;
      end else begin
         pend_ff   <= csr_we;
         sa_vld_ff <= pend_ff;
         sb_vld_ff <= sa_vld_ff;
         sc_vld_ff <= sb_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      // products of the axis with itself and with the sine
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            nn_ff[i][j] <= PROD_W'(axis_ff[i]) * PROD_W'(axis_ff[j]);
         end
         sn_ff[i] <= PROD_W'(sin_ff) * PROD_W'(axis_ff[i]);
      end
      omc_ff <= ONE_Q - OMC_W'(cos_ff);

      // round half up back to the fraction format
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            nnr_ff[i][j] <= NN_W'((PS_W'(nn_ff[i][j]) + HALF_P) >>> FRAC_BITS);
         end
         snr_ff[i] <= NN_W'((PS_W'(sn_ff[i]) + HALF_P) >>> FRAC_BITS);
      end
      omcb_ff <= omc_ff;

      // outer product scaled by one minus cosine
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            po_ff[i][j] <= PO_W'(nnr_ff[i][j]) * PO_W'(omcb_ff);
         end
         snc_ff[i] <= snr_ff[i];
      end
   end

   // skew-symmetric cross product part
   always_comb begin
      cross_e[0][0] = '0;
      cross_e[1][1] = '0;
      cross_e[2][2] = '0;
      cross_e[0][1] = -ENT_W'(snc_ff[2]);
      cross_e[1][0] = ENT_W'(snc_ff[2]);
      cross_e[0][2] = ENT_W'(snc_ff[1]);
      cross_e[2][0] = -ENT_W'(snc_ff[1]);
      cross_e[1][2] = -ENT_W'(snc_ff[0]);
      cross_e[2][1] = ENT_W'(snc_ff[0]);
   end

   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         for (int j = 0; j < DIM; j++) begin
            rnd_e[i][j] = (ENT_W'(po_ff[i][j]) + HALF_E) >>> FRAC_BITS;
            sum_e[i][j] = rnd_e[i][j] + cross_e[i][j]
                        + ((i == j) ? ENT_W'(cos_ff) : ENT_W'(0));
            if (sum_e[i][j] > MAT_HI) begin
               sat_e[i][j] = MAT_HI[MW-1:0];
            end else if (sum_e[i][j] < MAT_LO) begin
               sat_e[i][j] = MAT_LO[MW-1:0];
            end else begin
               sat_e[i][j] = sum_e[i][j][MW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sc_vld_ff) begin
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               mat_ff[DIM*i+j] <= sat_e[i][j];
            end
         end
      end
   end

   assign matrix = mat_ff;
   assign busy   = csr_we | pend_ff | sa_vld_ff | sb_vld_ff | sc_vld_ff;

endmodule

### src/axis_angle_vector_rotator_top.sv
// Rotates a stream of 3-axis samples by the Rodrigues matrix of a configured axis and
// angle (cos and sin given directly, all signed Q1.14). One request is taken per clock
// while req_bus.ready is high, and each gives one rotated, rounded and saturated
// response: the datapath has three register stages (nine matrix-by-sample products, row
// sums, then round and saturate), so throughput is one sample per cycle whenever the
// response side takes them. The matrix is rebuilt by its own four-stage pipeline after
// reset and after every csr write; from the write cycle until the rebuilt matrix is
// registered, req_bus.ready stays low. Write csr registers only while no request is in
// flight. The last flag rides along with its sample untouched.
`include "assert_macros.svh"

module axis_angle_vector_rotator_top #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int FRAC_BITS    = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   avr_req_if.sink                             req_bus,
   avr_rsp_if.source                           rsp_bus,
   input  logic                                csr_we,
   input  logic [avr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [avr_pkg::CFG_WIDTH-1:0]       csr_wdata
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int DIM   = avr_pkg::MAT_DIM;
   localparam int PR_W  = avr_pkg::MAT_WIDTH + SW;
   // room for three products plus the rounding half
   localparam int ACC_W = ((PR_W > FRAC_BITS) ? PR_W : FRAC_BITS) + 3;

   localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) << (FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] OUT_HI = (ACC_W'(1) << (SW - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] OUT_LO = ~OUT_HI;

   avr_pkg::matrix_type matrix;
   logic                bld_busy;

   // matrix build from the csr registers
   avr_matrix_builder #(
      .FRAC_BITS (FRAC_BITS)
   ) u_builder (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .matrix    (matrix),
      .busy      (bld_busy)
   );

   logic signed [SW-1:0] smp [DIM];
   logic                 req_acc;
   logic                 en1;
   logic                 en2;
   logic                 en3;

   // stage 1: products
   logic                   s1_vld_ff;
   logic                   s1_vld_in;
   logic                   s1_last_ff;
   logic signed [PR_W-1:0] s1_prod_ff [DIM][DIM];

   // stage 2: row sums with the rounding half folded in
   logic                    s2_vld_ff;
   logic                    s2_vld_in;
   logic                    s2_last_ff;
   logic signed [ACC_W-1:0] s2_acc_ff [DIM];

   // stage 3: output register, scaled and saturated
   logic                    s3_vld_ff;
   logic                    s3_vld_in;
   logic                    s3_last_ff;
   logic signed [ACC_W-1:0] shifted [DIM];
   logic signed [SW-1:0]    s3_rot_in [DIM];
   logic signed [SW-1:0]    s3_rot_ff [DIM];

   assign smp[0] = req_bus.sample_x;
   assign smp[1] = req_bus.sample_y;
   assign smp[2] = req_bus.sample_z;

   // a stage moves when it is empty or its successor moves, so bubbles close up
   assign en3 = !s3_vld_ff || rsp_bus.ready;
   assign en2 = !s2_vld_ff || en3;
   assign en1 = !s1_vld_ff || en2;

   // hold off requests while the matrix is being rebuilt
   assign req_bus.ready = en1 && !bld_busy;
   assign req_acc       = req_bus.valid && req_bus.ready;

   assign s1_vld_in = en1 ? req_acc   : s1_vld_ff;
   assign s2_vld_in = en2 ? s1_vld_ff : s2_vld_ff;
   assign s3_vld_in = en3 ? s2_vld_ff : s3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_last_ff <= req_bus.last;
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               s1_prod_ff[i][j] <= PR_W'($signed(matrix[DIM*i+j])) * PR_W'(smp[j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_last_ff <= s1_last_ff;
         for (int i = 0; i < DIM; i++) begin
            s2_acc_ff[i] <= ACC_W'(s1_prod_ff[i][0]) + ACC_W'(s1_prod_ff[i][1])
                          + ACC_W'(s1_prod_ff[i][2]) + HALF_A;
         end
      end
   end

   // floor of the rounded sum, then clamp to the sample range
   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         shifted[i] = s2_acc_ff[i] >>> FRAC_BITS;
         if (shifted[i] > OUT_HI) begin
            s3_rot_in[i] = OUT_HI[SW-1:0];
         end else if (shifted[i] < OUT_LO) begin
            s3_rot_in[i] = OUT_LO[SW-1:0];
         end else begin
            s3_rot_in[i] = shifted[i][SW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_last_ff <= s2_last_ff;
         for (int i = 0; i < DIM; i++) begin
            s3_rot_ff[i] <= s3_rot_in[i];
         end
      end
   end

   assign rsp_bus.valid    = s3_vld_ff;
   assign rsp_bus.rot_x    = s3_rot_ff[0];
   assign rsp_bus.rot_y    = s3_rot_ff[1];
   assign rsp_bus.rot_z    = s3_rot_ff[2];
   assign rsp_bus.last_out = s3_last_ff;

   // no request may slip in before the rebuilt matrix lands
   `AVR_ASSERT_RST(a_rebuild_blocks, clock, reset, csr_we |=> !req_acc ##1 !req_acc ##1 !req_acc ##1 !req_acc, "request accepted during matrix rebuild")
   // the matrix is built after reset before any request
   `AVR_ASSERT(a_reset_builds, clock, reset |=> !req_bus.ready, "ready raised straight after reset")
   // a held product stage keeps its item
   `AVR_ASSERT_RST(a_s1_hold, clock, reset, s1_vld_ff && !en2 |=> s1_vld_ff && $stable(s1_last_ff), "stalled product stage lost its item")
   // an empty front stage takes requests when no build is running
   `AVR_ASSERT_RST(a_front_free, clock, reset, !s1_vld_ff && !bld_busy |-> req_bus.ready, "empty pipeline refused a request")

endmodule
